>>> src/tsp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package tsp_pkg;
    localparam int DEF_NODES = 4;
    localparam logic [9:0] NO_EDGE = 10'd999;
    localparam logic [19:0] BOUND_MAX = 20'hFFFFF;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_CAND,
        ST_RED_MIN,
        ST_RED_SUB,
        ST_SCORE,
        ST_NEXT,
        ST_COMMIT,
        ST_EMIT,
        ST_COPY
    } state_t;

    function automatic logic [19:0] sat_add(input logic [19:0] a, input logic [19:0] b);
        logic [20:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[20] ? BOUND_MAX : s[19:0];
    endfunction
endpackage
`default_nettype wire

>>> src/tsp_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface tsp_in_if;
    logic       valid;
    logic       ready;
    logic [9:0] edge_cost;
    logic       last_entry;
    modport source (output valid, edge_cost, last_entry, input ready);
    modport sink (input valid, edge_cost, last_entry, output ready);
endinterface

interface tsp_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  tour_node;
    logic [19:0] bound_cost;
    logic        last_node;
    modport source (output valid, tour_node, bound_cost, last_node, input ready);
    modport sink (input valid, tour_node, bound_cost, last_node, output ready);
endinterface
`default_nettype wire

>>> src/tsp_reduced_matrix_tour.sv
// after the last matrix item the root matrix is reduced in place, then per level each
// unvisited candidate is copied, reduced and scored, each visited one is skipped, the best
// is committed and one node is emitted; the search waits while a result waits at the output
// throughput: one matrix item per cycle while loading and no result waits at the output,
// no item taken during the search
// reset: rst_n asynchronous, clears control state, start node 0; matrices undefined
`timescale 1ns / 1ps
`default_nettype none
module tsp_reduced_matrix_tour #(
    parameter int NODES = tsp_pkg::DEF_NODES
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic cfg_we,
    input  wire logic [1:0] cfg_wdata,
    tsp_in_if.sink  in_ch,
    tsp_out_if.source out_ch
);
    import tsp_pkg::*;

    localparam int NB = (NODES > 1) ? $clog2(NODES) : 1;
    localparam int CELLS = NODES * NODES;
    localparam int CB = $clog2(CELLS);

    // three matrix stores; cand is the working copy for each candidate
    logic [9:0] cur_mem  [CELLS];
    logic [9:0] cand_mem [CELLS];
    logic [9:0] best_mem [CELLS];

    state_t state_reg, state_next;
    logic [1:0]  start_cfg_reg;
    logic [CB-1:0] load_cnt_reg;
    logic [NODES-1:0] visited_reg;
    logic [NB-1:0] cur_node_reg, start_reg;
    logic [19:0] bound_reg;
    logic [NB-1:0] cand_reg, best_node_reg;
    logic [20:0] best_reg;        // bit 20 marks "nothing chosen yet"
    logic        root_reg;        // reducing the root matrix in place
    logic        pass_reg;        // 0 rows, 1 columns
    logic [NB-1:0] line_reg, pos_reg;
    logic [9:0]  lo_reg;
    logic [19:0] red_reg;
    logic [CB-1:0] cell_reg;
    logic [NB-1:0] level_reg;
    logic        emit_last_reg;
    logic        ovalid_reg;
    logic [1:0]  onode_reg;
    logic [19:0] obound_reg;
    logic        olast_reg;

    // cell address of the reduction sweep
    logic [CB-1:0] red_addr;
    always_comb
    begin
        if (pass_reg)
            red_addr = CB'(int'(pos_reg) * NODES + int'(line_reg));
        else
            red_addr = CB'(int'(line_reg) * NODES + int'(pos_reg));
    end

    // the working matrix: cur when reducing the root, else cand
    logic [9:0] work_rd;
    assign work_rd = root_reg ? cur_mem[red_addr] : cand_mem[red_addr];

    // blocking test for the copy sweep; line and pos follow the row and column of cell_reg
    logic blocked;
    always_comb
    begin
        blocked = (line_reg == cur_node_reg) || (pos_reg == cand_reg)
            || ((line_reg == cand_reg) && ((pos_reg == start_reg) || (pos_reg == cur_node_reg)));
    end

    logic [19:0] score;
    assign score = sat_add(sat_add(20'(cur_mem[CB'(int'(cur_node_reg) * NODES
        + int'(cand_reg))]), bound_reg), red_reg);

    logic last_pos;
    assign last_pos = (int'(pos_reg) == NODES - 1);
    logic last_line;
    assign last_line = (int'(line_reg) == NODES - 1);
    logic last_cell;
    assign last_cell = (int'(cell_reg) == CELLS - 1);

    assign in_ch.ready = (state_reg == ST_LOAD) && !ovalid_reg;
    assign out_ch.valid = ovalid_reg;
    assign out_ch.tour_node = onode_reg;
    assign out_ch.bound_cost = obound_reg;
    assign out_ch.last_node = olast_reg;

    logic in_acc;
    assign in_acc = in_ch.valid && in_ch.ready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_LOAD:    if (in_acc && in_ch.last_entry) state_next = ST_RED_MIN;
            ST_CAND:    state_next = visited_reg[cand_reg] ? ST_NEXT : ST_COPY;
            ST_COPY:    if (last_cell) state_next = ST_RED_MIN;
            ST_RED_MIN: if (last_pos) state_next = ST_RED_SUB;
            ST_RED_SUB:
                if (last_pos)
                begin
                    if (last_line && pass_reg)
                        state_next = root_reg ? ST_EMIT : ST_SCORE;
                    else
                        state_next = ST_RED_MIN;
                end
            ST_SCORE:   state_next = ST_NEXT;
            ST_NEXT:    state_next = (int'(cand_reg) == NODES - 1) ? ST_COMMIT : ST_CAND;
            ST_COMMIT:  if (last_cell) state_next = ST_EMIT;
            ST_EMIT:    if (!ovalid_reg)
                            state_next = emit_last_reg ? ST_LOAD : ST_CAND;
            default:    state_next = ST_LOAD;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            start_cfg_reg <= '0;
            load_cnt_reg <= '0;
            visited_reg <= '0;
            cur_node_reg <= '0;
            bound_reg <= '0;
            ovalid_reg <= 1'b0;
            root_reg <= 1'b0;
            pass_reg <= 1'b0;
            line_reg <= '0;
            pos_reg <= '0;
            cell_reg <= '0;
            cand_reg <= '0;
            level_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
                start_cfg_reg <= cfg_wdata;
            if (ovalid_reg && out_ch.ready)
                ovalid_reg <= 1'b0;
            case (state_reg)
                ST_LOAD:
                    if (in_acc)
                    begin
                        if (in_ch.last_entry || int'(load_cnt_reg) == CELLS - 1)
                            load_cnt_reg <= '0;
                        else
                            load_cnt_reg <= load_cnt_reg + 1'b1;
                        if (in_ch.last_entry)
                        begin
                            root_reg <= 1'b1;
                            pass_reg <= 1'b0;
                            line_reg <= '0;
                            pos_reg <= '0;
                            red_reg <= '0;
                            lo_reg <= NO_EDGE;
                            level_reg <= '0;
                            if (int'(start_cfg_reg) < NODES)
                                start_reg <= NB'(start_cfg_reg);
                            else
                                start_reg <= '0;
                        end
                    end
                ST_CAND:
                begin
                    cell_reg <= '0;
                    line_reg <= '0;
                    pos_reg <= '0;
                end
                ST_COPY:
                begin
                    cell_reg <= cell_reg + 1'b1;
                    pos_reg <= last_pos ? '0 : pos_reg + 1'b1;
                    if (last_pos)
                        line_reg <= last_line ? '0 : line_reg + 1'b1;
                    if (last_cell)
                    begin
                        root_reg <= 1'b0;
                        pass_reg <= 1'b0;
                        red_reg <= '0;
                        lo_reg <= NO_EDGE;
                    end
                end
                ST_RED_MIN:
                begin
                    if (work_rd < lo_reg)
                        lo_reg <= work_rd;
                    pos_reg <= last_pos ? '0 : pos_reg + 1'b1;
                end
                ST_RED_SUB:
                begin
                    pos_reg <= last_pos ? '0 : pos_reg + 1'b1;
                    if (last_pos)
                    begin
                        if (lo_reg != NO_EDGE)
                            red_reg <= sat_add(red_reg, 20'(lo_reg));
                        lo_reg <= NO_EDGE;
                        line_reg <= last_line ? '0 : line_reg + 1'b1;
                        if (last_line)
                            pass_reg <= 1'b1;
                        if (last_line && pass_reg && root_reg)
                        begin
                            bound_reg <= sat_add(red_reg,
                                (lo_reg != NO_EDGE) ? 20'(lo_reg) : 20'd0);
                            visited_reg <= NODES'(1) << start_reg;
                            cur_node_reg <= start_reg;
                            emit_last_reg <= (NODES < 2);
                            cand_reg <= '0;
                            best_reg <= {1'b1, 20'd0};
                        end
                    end
                end
                ST_SCORE:
                    if (best_reg[20] || score < best_reg[19:0])
                    begin
                        best_reg <= {1'b0, score};
                        best_node_reg <= cand_reg;
                    end
                ST_NEXT:
                begin
                    cand_reg <= cand_reg + 1'b1;
                    cell_reg <= '0;
                end
                ST_COMMIT:
                begin
                    cell_reg <= cell_reg + 1'b1;
                    if (last_cell)
                    begin
                        bound_reg <= best_reg[19:0];
                        visited_reg[best_node_reg] <= 1'b1;
                        cur_node_reg <= best_node_reg;
                        level_reg <= level_reg + 1'b1;
                        emit_last_reg <= (int'(level_reg) + 1 == NODES - 1);
                    end
                end
                ST_EMIT:
                    if (!ovalid_reg)
                    begin
                        // result fields only change once the previous item has gone
                        ovalid_reg <= 1'b1;
                        onode_reg <= 2'(cur_node_reg);
                        obound_reg <= bound_reg;
                        olast_reg <= emit_last_reg;
                        cand_reg <= '0;
                        best_reg <= {1'b1, 20'd0};
                    end
                default: ;
            endcase
        end
    end

    // matrix stores
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_LOAD && in_acc)
            cur_mem[load_cnt_reg] <= (in_ch.edge_cost > NO_EDGE) ? NO_EDGE : in_ch.edge_cost;
        if (state_reg == ST_RED_SUB && root_reg && work_rd != NO_EDGE)
            cur_mem[red_addr] <= work_rd - lo_reg;
        if (state_reg == ST_COMMIT)
            cur_mem[cell_reg] <= best_mem[cell_reg];
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_COPY)
            cand_mem[cell_reg] <= blocked ? NO_EDGE : cur_mem[cell_reg];
        if (state_reg == ST_RED_SUB && !root_reg && work_rd != NO_EDGE)
            cand_mem[red_addr] <= work_rd - lo_reg;
    end

    // best child copy: the sweep starts in the cycle after a winning score
    logic        save_reg;
    logic [CB-1:0] save_cnt_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            save_reg <= 1'b0;
            save_cnt_reg <= '0;
        end
        else if (state_reg == ST_SCORE && (best_reg[20] || score < best_reg[19:0]))
        begin
            save_reg <= 1'b1;
            save_cnt_reg <= '0;
        end
        else if (save_reg)
        begin
            save_cnt_reg <= save_cnt_reg + 1'b1;
            if (int'(save_cnt_reg) == CELLS - 1)
                save_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (save_reg)
            best_mem[save_cnt_reg] <= cand_mem[save_cnt_reg];
    end

    // the save sweep stays two cells ahead of the next copy into cand
    // and one cell ahead of the commit sweep that reads best

    // assertions
    a_no_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_LOAD) |-> !in_ch.ready)
        else $error("input taken during search");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && !out_ch.ready) |=> $stable(out_ch.bound_cost))
        else $error("result changed while stalled");
    a_visit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CAND) |-> (visited_reg != '0))
        else $error("no node visited during search");
endmodule
`default_nettype wire
